>>> design/llca_pkg.sv
// ----------------------------------------------------------------------------
// llca_pkg
// Shared widths, register indexes and payload types of the closest-approach
// pipeline.
// ----------------------------------------------------------------------------
package llca_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int DIR_WIDTH   = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_WIDTH;

    // Datapath widths, most derived from the coordinate and direction widths.
    localparam int MAB_W  = COORD_WIDTH + 1;
    localparam int PROD_W = MAB_W + DIR_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int PC_W   = 2 * DIR_WIDTH;
    localparam int C_W    = PC_W + 2;
    localparam int CM_W   = 32;
    localparam int CSQ_W  = 2 * CM_W;
    localparam int PPL_W  = 33 + C_W;
    localparam int PPH_W  = SUM_W - 32 + C_W;
    localparam int N_W    = SUM_W + C_W + 1;
    localparam int FRAC_SHIFT = 14;
    localparam int DIV_X_W = N_W + FRAC_SHIFT;
    // The divisor exceeds 2^36 whenever the lines are not parallel.
    localparam int DIV_Q_W = DIV_X_W - 36;
    localparam int DIV_D_W = CSQ_W;
    localparam int DIV_SIDE_W = 3 * COORD_WIDTH + 3 * DIR_WIDTH + 4;
    localparam int SAT_W = DIV_Q_W + 4;

    localparam logic [CSQ_W-1:0] ONE_Q56   = 64'h0100_0000_0000_0000;
    localparam logic [CSQ_W-1:0] PAR_LIMIT = 64'd72057594037;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_AXIS_X   = 3'd3,
        CFG_AXIS_Y   = 3'd4,
        CFG_AXIS_Z   = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic signed [DIR_WIDTH-1:0]   dir_x;
        logic signed [DIR_WIDTH-1:0]   dir_y;
        logic signed [DIR_WIDTH-1:0]   dir_z;
        logic                          force_forward;
    } trk_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] hit_x;
        logic signed [COORD_WIDTH-1:0] hit_y;
        logic signed [COORD_WIDTH-1:0] hit_z;
        logic signed [COORD_WIDTH-1:0] path_length;
        logic                          valid_res;
    } res_t;

    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage

>>> design/llca_div.sv
// ----------------------------------------------------------------------------
// llca_div
// Pipelined restoring divider, one quotient bit per register stage, with a
// sideband word that travels alongside each item.
// ----------------------------------------------------------------------------
module llca_div import llca_pkg::*;
#(
    parameter int Q_BITS    = DIV_Q_W,
    parameter int X_BITS    = DIV_X_W,
    parameter int SIDE_BITS = DIV_SIDE_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pipe_ctl_t            ctl,
    input  logic [X_BITS-1:0]    dividend,
    input  logic [DIV_D_W-1:0]   divisor,
    input  logic [SIDE_BITS-1:0] side_in,
    output logic                 out_valid,
    output logic [Q_BITS-1:0]    quotient,
    output logic [SIDE_BITS-1:0] side_out
);

    logic                 v_reg    [Q_BITS];
    logic [DIV_D_W-1:0]   rem_reg  [Q_BITS];
    logic [Q_BITS-1:0]    xq_reg   [Q_BITS];
    logic [DIV_D_W-1:0]   d_reg    [Q_BITS];
    logic [SIDE_BITS-1:0] side_reg [Q_BITS];

    for (genvar k = 0; k < Q_BITS; k++)
    begin : g_stage
        logic                 v_in;
        logic [DIV_D_W-1:0]   rem_in;
        logic [Q_BITS-1:0]    xq_in;
        logic [DIV_D_W-1:0]   d_in;
        logic [SIDE_BITS-1:0] side_k;
        logic [DIV_D_W:0]     trial;
        logic [DIV_D_W+1:0]   diff;
        logic                 take;
        logic [DIV_D_W-1:0]   rem_next;

        if (k == 0)
        begin : g_first
            // The upper dividend bits start as the partial remainder.
            assign v_in   = ctl.valid;
            assign rem_in = DIV_D_W'(dividend[X_BITS-1:Q_BITS]);
            assign xq_in  = dividend[Q_BITS-1:0];
            assign d_in   = divisor;
            assign side_k = side_in;
        end
        else
        begin : g_next
            assign v_in   = v_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign xq_in  = xq_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign side_k = side_reg[k-1];
        end

        assign trial    = {rem_in, xq_in[Q_BITS-1]};
        assign diff     = {1'b0, trial} - {2'b00, d_in};
        assign take     = !diff[DIV_D_W+1];
        assign rem_next = take ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (ctl.en)
            begin
                v_reg[k] <= v_in;
            end
        end

        // Dividend bits leave at the top as quotient bits enter at the bottom.
        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg[k]  <= rem_next;
                xq_reg[k]   <= {xq_in[Q_BITS-2:0], take};
                d_reg[k]    <= d_in;
                side_reg[k] <= side_k;
            end
        end
    end

    assign out_valid = v_reg[Q_BITS-1];
    assign quotient  = xq_reg[Q_BITS-1];
    assign side_out  = side_reg[Q_BITS-1];

endmodule

>>> design/line_line_closest_approach.sv
// ----------------------------------------------------------------------------
// line_line_closest_approach
// Closest point of a streamed track line to a configured reference line.
// ----------------------------------------------------------------------------
// Every item passes the front stages, the restoring divider that resolves one
// quotient bit per stage, and the post stages. Throughput: one item per cycle
// while no result is stalled.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Reset clears every valid bit and loads the reference line defaults.
// ----------------------------------------------------------------------------
module line_line_closest_approach import llca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  trk_valid,
    output logic                  trk_stall,
    input  trk_t                  trk,
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_t                  res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int M_W  = DIV_Q_W + DIR_WIDTH;
    localparam int HI_W = SUM_W - 32;

    localparam logic signed [SAT_W-1:0] SAT_MAX =
        {{(SAT_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SAT_MIN =
        {{(SAT_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [SAT_W-1:0] v);
        logic signed [COORD_WIDTH-1:0] r;
        if (v > SAT_MAX)
            r = SAT_MAX[COORD_WIDTH-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[COORD_WIDTH-1:0];
        else
            r = v[COORD_WIDTH-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] center_reg [3];
    logic signed [DIR_WIDTH-1:0]   axis_reg   [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            axis_reg[0]   <= '0;
            axis_reg[1]   <= '0;
            axis_reg[2]   <= DIR_WIDTH'(16384);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_CENTER_X: center_reg[0] <= cfg_data[COORD_WIDTH-1:0];
                CFG_CENTER_Y: center_reg[1] <= cfg_data[COORD_WIDTH-1:0];
                CFG_CENTER_Z: center_reg[2] <= cfg_data[COORD_WIDTH-1:0];
                CFG_AXIS_X:   axis_reg[0]   <= cfg_data[DIR_WIDTH-1:0];
                CFG_AXIS_Y:   axis_reg[1]   <= cfg_data[DIR_WIDTH-1:0];
                CFG_AXIS_Z:   axis_reg[2]   <= cfg_data[DIR_WIDTH-1:0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: every stage moves together unless a result is stuck.
    // ------------------------------------------------------------------
    logic      en;
    pipe_ctl_t div_ctl;

    assign en        = !(res_valid && res_stall);
    assign trk_stall = !en;

    logic signed [COORD_WIDTH-1:0] in_pos [3];
    logic signed [DIR_WIDTH-1:0]   in_dir [3];

    assign in_pos[0] = trk.pos_x;
    assign in_pos[1] = trk.pos_y;
    assign in_pos[2] = trk.pos_z;
    assign in_dir[0] = trk.dir_x;
    assign in_dir[1] = trk.dir_y;
    assign in_dir[2] = trk.dir_z;

    // ------------------------------------------------------------------
    // Stage 1: offsets to the reference center, direction products
    // ------------------------------------------------------------------
    logic                          s1_v_reg;
    logic signed [COORD_WIDTH-1:0] s1_ma_reg  [3];
    logic signed [DIR_WIDTH-1:0]   s1_a_reg   [3];
    logic signed [MAB_W-1:0]       s1_mab_reg [3];
    logic signed [PC_W-1:0]        s1_pc_reg  [3];
    logic                          s1_fwd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_ma_reg[i]  <= in_pos[i];
                s1_a_reg[i]   <= in_dir[i];
                s1_mab_reg[i] <= MAB_W'(center_reg[i]) - MAB_W'(in_pos[i]);
                s1_pc_reg[i]  <= PC_W'(in_dir[i]) * PC_W'(axis_reg[i]);
            end
            s1_fwd_reg <= trk.force_forward;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cosine between the lines, offset projections per axis
    // ------------------------------------------------------------------
    logic                          s2_v_reg;
    logic signed [COORD_WIDTH-1:0] s2_ma_reg  [3];
    logic signed [DIR_WIDTH-1:0]   s2_a_reg   [3];
    logic signed [C_W-1:0]         s2_c_reg;
    logic signed [PROD_W-1:0]      s2_pma_reg [3];
    logic signed [PROD_W-1:0]      s2_pmb_reg [3];
    logic                          s2_fwd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_ma_reg[i]  <= s1_ma_reg[i];
                s2_a_reg[i]   <= s1_a_reg[i];
                s2_pma_reg[i] <= PROD_W'(s1_mab_reg[i]) * PROD_W'(s1_a_reg[i]);
                s2_pmb_reg[i] <= PROD_W'(s1_mab_reg[i]) * PROD_W'(axis_reg[i]);
            end
            s2_c_reg   <= C_W'(s1_pc_reg[0]) + C_W'(s1_pc_reg[1]) + C_W'(s1_pc_reg[2]);
            s2_fwd_reg <= s1_fwd_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: projection sums, squared cosine
    // ------------------------------------------------------------------
    logic                          s3_v_reg;
    logic signed [COORD_WIDTH-1:0] s3_ma_reg [3];
    logic signed [DIR_WIDTH-1:0]   s3_a_reg  [3];
    logic signed [SUM_W-1:0]       s3_sa_reg;
    logic signed [SUM_W-1:0]       s3_sb_reg;
    logic signed [C_W-1:0]         s3_c_reg;
    logic [CSQ_W-1:0]              s3_csq_reg;
    logic                          s3_fwd_reg;
    logic [C_W-1:0]                s2_cabs_full;
    logic [CM_W-1:0]               s2_cabs;

    assign s2_cabs_full = s2_c_reg[C_W-1] ? C_W'(-s2_c_reg) : C_W'(s2_c_reg);
    assign s2_cabs      = s2_cabs_full[CM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s3_ma_reg[i] <= s2_ma_reg[i];
                s3_a_reg[i]  <= s2_a_reg[i];
            end
            s3_sa_reg  <= SUM_W'(s2_pma_reg[0]) + SUM_W'(s2_pma_reg[1])
                        + SUM_W'(s2_pma_reg[2]);
            s3_sb_reg  <= SUM_W'(s2_pmb_reg[0]) + SUM_W'(s2_pmb_reg[1])
                        + SUM_W'(s2_pmb_reg[2]);
            s3_c_reg   <= s2_c_reg;
            s3_csq_reg <= CSQ_W'(s2_cabs) * CSQ_W'(s2_cabs);
            s3_fwd_reg <= s2_fwd_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: denominator and parallel test, axis term in two halves
    // ------------------------------------------------------------------
    logic                          s4_v_reg;
    logic signed [COORD_WIDTH-1:0] s4_ma_reg [3];
    logic signed [DIR_WIDTH-1:0]   s4_a_reg  [3];
    logic signed [SUM_W-1:0]       s4_sa_reg;
    logic signed [PPL_W-1:0]       s4_ppl_reg;
    logic signed [PPH_W-1:0]       s4_pph_reg;
    logic [DIV_D_W-1:0]            s4_ad_reg;
    logic                          s4_dneg_reg;
    logic                          s4_par_reg;
    logic                          s4_fwd_reg;
    logic                          s3_dneg;
    logic [DIV_D_W-1:0]            s3_ad;
    logic signed [HI_W-1:0]        s3_sb_hi;
    logic signed [32:0]            s3_sb_lo;

    assign s3_dneg  = s3_csq_reg > ONE_Q56;
    assign s3_ad    = s3_dneg ? (s3_csq_reg - ONE_Q56) : (ONE_Q56 - s3_csq_reg);
    assign s3_sb_hi = s3_sb_reg[SUM_W-1:32];
    assign s3_sb_lo = $signed({1'b0, s3_sb_reg[31:0]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s4_ma_reg[i] <= s3_ma_reg[i];
                s4_a_reg[i]  <= s3_a_reg[i];
            end
            s4_sa_reg   <= s3_sa_reg;
            s4_ppl_reg  <= PPL_W'(s3_sb_lo) * PPL_W'(s3_c_reg);
            s4_pph_reg  <= PPH_W'(s3_sb_hi) * PPH_W'(s3_c_reg);
            s4_ad_reg   <= s3_ad;
            s4_dneg_reg <= s3_dneg;
            s4_par_reg  <= s3_ad <= PAR_LIMIT;
            s4_fwd_reg  <= s3_fwd_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: numerator  sa * 2^28 - sb * c
    // ------------------------------------------------------------------
    logic                          s5_v_reg;
    logic signed [COORD_WIDTH-1:0] s5_ma_reg [3];
    logic signed [DIR_WIDTH-1:0]   s5_a_reg  [3];
    logic signed [N_W-1:0]         s5_n_reg;
    logic [DIV_D_W-1:0]            s5_ad_reg;
    logic                          s5_dneg_reg;
    logic                          s5_par_reg;
    logic                          s5_fwd_reg;
    logic signed [N_W-1:0]         s4_sa_sh;
    logic signed [N_W-1:0]         s4_hi_sh;

    assign s4_sa_sh = N_W'(s4_sa_reg) <<< 28;
    assign s4_hi_sh = N_W'(s4_pph_reg) <<< 32;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s5_ma_reg[i] <= s4_ma_reg[i];
                s5_a_reg[i]  <= s4_a_reg[i];
            end
            s5_n_reg    <= s4_sa_sh - s4_hi_sh - N_W'(s4_ppl_reg);
            s5_ad_reg   <= s4_ad_reg;
            s5_dneg_reg <= s4_dneg_reg;
            s5_par_reg  <= s4_par_reg;
            s5_fwd_reg  <= s4_fwd_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: dividend magnitude and quotient sign
    // ------------------------------------------------------------------
    logic                          s6_v_reg;
    logic [DIV_X_W-1:0]            s6_x_reg;
    logic [DIV_D_W-1:0]            s6_ad_reg;
    logic [DIV_SIDE_W-1:0]         s6_side_reg;
    logic                          s5_nneg;
    logic [N_W-1:0]                s5_nmag;

    assign s5_nneg = s5_n_reg[N_W-1];
    assign s5_nmag = s5_nneg ? N_W'(-s5_n_reg) : N_W'(s5_n_reg);

    // A positive exact quotient keeps the forward flag even if lambda
    // truncates to zero.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_x_reg    <= {s5_nmag, {FRAC_SHIFT{1'b0}}};
            s6_ad_reg   <= s5_ad_reg;
            s6_side_reg <= {s5_ma_reg[0], s5_ma_reg[1], s5_ma_reg[2],
                            s5_a_reg[0], s5_a_reg[1], s5_a_reg[2],
                            s5_fwd_reg, s5_par_reg, s5_nneg ^ s5_dneg_reg,
                            (s5_n_reg != '0) && (s5_nneg == s5_dneg_reg)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= trk_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider
    // ------------------------------------------------------------------
    logic                  div_v;
    logic [DIV_Q_W-1:0]    div_q;
    logic [DIV_SIDE_W-1:0] div_side;

    assign div_ctl.en    = en;
    assign div_ctl.valid = s6_v_reg;

    llca_div #(
        .Q_BITS    (DIV_Q_W),
        .X_BITS    (DIV_X_W),
        .SIDE_BITS (DIV_SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (s6_x_reg),
        .divisor   (s6_ad_reg),
        .side_in   (s6_side_reg),
        .out_valid (div_v),
        .quotient  (div_q),
        .side_out  (div_side)
    );

    logic signed [COORD_WIDTH-1:0] d_ma [3];
    logic signed [DIR_WIDTH-1:0]   d_a  [3];
    logic                          d_fwd;
    logic                          d_par;
    logic                          d_lneg;
    logic                          d_pos;

    assign {d_ma[0], d_ma[1], d_ma[2], d_a[0], d_a[1], d_a[2],
            d_fwd, d_par, d_lneg, d_pos} = div_side;

    // ------------------------------------------------------------------
    // Post stage 1: lambda times each direction component
    // ------------------------------------------------------------------
    logic                          p1_v_reg;
    logic [M_W-1:0]                p1_m_reg   [3];
    logic                          p1_neg_reg [3];
    logic signed [COORD_WIDTH-1:0] p1_ma_reg  [3];
    logic [DIV_Q_W-1:0]            p1_q_reg;
    logic                          p1_lneg_reg;
    logic                          p1_par_reg;
    logic                          p1_fwd_reg;
    logic                          p1_pos_reg;
    logic [DIR_WIDTH-1:0]          d_aabs [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            d_aabs[i] = d_a[i][DIR_WIDTH-1] ? DIR_WIDTH'(~d_a[i] + 1'b1) : d_a[i];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p1_m_reg[i]   <= M_W'(div_q) * M_W'(d_aabs[i]);
                p1_neg_reg[i] <= d_lneg ^ d_a[i][DIR_WIDTH-1];
                p1_ma_reg[i]  <= d_ma[i];
            end
            p1_q_reg    <= div_q;
            p1_lneg_reg <= d_lneg;
            p1_par_reg  <= d_par;
            p1_fwd_reg  <= d_fwd;
            p1_pos_reg  <= d_pos;
        end
    end

    // ------------------------------------------------------------------
    // Post stage 2: truncate, add to the track point, saturate
    // ------------------------------------------------------------------
    logic                          p2_v_reg;
    res_t                          res_reg;
    logic signed [SAT_W-1:0]       p1_step [3];
    logic signed [SAT_W-1:0]       p1_hit  [3];
    logic signed [SAT_W-1:0]       p1_qs;
    logic signed [SAT_W-1:0]       p1_lam;
    res_t                          res_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p1_step[i] = $signed({2'b00, p1_m_reg[i][M_W-1:FRAC_SHIFT]});
            if (p1_neg_reg[i])
                p1_step[i] = -p1_step[i];
            p1_hit[i] = SAT_W'(p1_ma_reg[i]) + p1_step[i];
        end
        p1_qs  = $signed({4'b0000, p1_q_reg});
        p1_lam = p1_lneg_reg ? -p1_qs : p1_qs;

        if (p1_par_reg)
        begin
            res_next.hit_x       = p1_ma_reg[0];
            res_next.hit_y       = p1_ma_reg[1];
            res_next.hit_z       = p1_ma_reg[2];
            res_next.path_length = '0;
            res_next.valid_res   = 1'b0;
        end
        else
        begin
            res_next.hit_x       = sat_coord(p1_hit[0]);
            res_next.hit_y       = sat_coord(p1_hit[1]);
            res_next.hit_z       = sat_coord(p1_hit[2]);
            res_next.path_length = sat_coord(p1_lam);
            res_next.valid_res   = p1_fwd_reg ? p1_pos_reg : 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_v_reg <= div_v;
            p2_v_reg <= p1_v_reg;
        end
    end

    assign res_valid = p2_v_reg;
    assign res       = res_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (trk_valid && !trk_stall) |=> s1_v_reg)
        else $error("accepted track did not enter the pipeline");

    a_parallel_out: assert property (@(posedge clk) disable iff (!rst_n)
        (en && p1_v_reg && p1_par_reg) |=>
        (!res.valid_res && res.path_length == '0))
        else $error("parallel lines gave a valid result or nonzero length");

    a_forward_gate: assert property (@(posedge clk) disable iff (!rst_n)
        (en && p1_v_reg && !p1_par_reg && p1_fwd_reg && !p1_pos_reg) |=>
        !res.valid_res)
        else $error("forward-only result marked valid without positive length");

    a_positive_len: assert property (@(posedge clk) disable iff (!rst_n)
        (en && p1_v_reg && !p1_par_reg && p1_pos_reg) |=>
        !res.path_length[COORD_WIDTH-1])
        else $error("positive quotient produced a negative path length");

endmodule
